// ===== hw/rtl/bdc_pkg.sv =====
// Package for the binary cross dilation block: sizes, codes, payload structs.
// Shared by every module under hw/rtl; depends on nothing else.
package bdc_pkg;

    // Store depth, height limit and the field widths.
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int REG_W        = 11;
    localparam int ROW_W        = 11;
    localparam int EW_W         = (REG_W > COL_W + 1) ? REG_W : COL_W + 1;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int PIX_W        = 24;
    localparam int CFG_IDX_W    = 1;

    localparam logic [7:0]       MARK_BLUE   = 8'hFF;
    localparam logic [PIX_W-1:0] WHITE_PIXEL = 24'hFFFFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Input transaction payload.
    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } out_item_t;

    // Per-item decisions made by the scan counters, consumed by the dilation stage.
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [COL_W-1:0] out_col;
        logic             left_ok;
        logic             right_ok;
        logic             upper_ok;
        logic             below_ok;
        logic             below_mark;
    } scan_info_t;

    // A pixel is marked when its blue byte is saturated.
    function automatic logic is_marked(input logic [PIX_W-1:0] pix);
        return pix[7:0] == MARK_BLUE;
    endfunction

endpackage

// ===== hw/rtl/binary_dilation_cross.sv =====
// Top level of the binary cross dilation block: ports and wiring of the units.
// Depends on bdc_pkg, bdc_scan_ctrl, bdc_row_store and bdc_dilate.
//
//  channel   handshake                  payload
//  input     in_valid / in_ready        in_data   (in_item_t: kind, pixel_in)
//  output    out_valid / out_ready      out_data  (out_item_t: pixel_out, frame_last)
//  config    cfg_write                  cfg_index, cfg_data (frame_width, frame_height)
//
// One transaction per clock is taken while the output is not stalled. A result is
// registered after the transaction that releases it and belongs to the pixel taken
// frame_width + 1 transactions earlier. The rate is set by the read-first line buffer
// and the upper-mark store, each accessed once per transaction. Reset clears counters
// and flags and sets both size registers to 600; the line stores are not cleared. A
// stalled output holds its result while one more transaction enters the stage.
module binary_dilation_cross (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bdc_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bdc_pkg::out_item_t            out_data,
    input  logic                          cfg_write,
    input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdc_pkg::REG_W-1:0]     cfg_data
);
    import bdc_pkg::*;

    logic             accept;
    logic             stage_free;
    logic [COL_W-1:0] row_addr;
    logic [PIX_W-1:0] row_rdata;
    scan_info_t       info;

    // Input transaction completes when the dilation stage can take it.
    assign in_ready = stage_free;
    assign accept   = in_valid && stage_free;

    bdc_scan_ctrl u_scan_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_data   (in_data),
        .row_addr  (row_addr),
        .info      (info)
    );

    bdc_row_store u_row_store (
        .clk     (clk),
        .en      (accept),
        .addr    (row_addr),
        .wr_data (in_data.pixel_in),
        .rd_data (row_rdata)
    );

    bdc_dilate u_dilate (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .info       (info),
        .row_rdata  (row_rdata),
        .stage_free (stage_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ===== hw/rtl/bdc_row_store.sv =====
// Line buffer holding the last pixel seen in each column (read-first RAM).
// Depends on bdc_pkg for widths.
module bdc_row_store (
    input  logic                      clk,
    input  logic                      en,
    input  logic [bdc_pkg::COL_W-1:0] addr,
    input  logic [bdc_pkg::PIX_W-1:0] wr_data,
    output logic [bdc_pkg::PIX_W-1:0] rd_data
);
    import bdc_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    // Read the old column entry and replace it with the new pixel in one access.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= mem[addr];
            mem[addr]   <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bdc_scan_ctrl.sv =====
// Configuration registers and raster counters for the input and output scans.
// Depends on bdc_pkg; produces the per-item scan_info_t for the dilation stage.
module bdc_scan_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdc_pkg::REG_W-1:0]     cfg_data,
    input  logic                          accept,
    input  bdc_pkg::in_item_t             in_data,
    output logic [bdc_pkg::COL_W-1:0]     row_addr,
    output bdc_pkg::scan_info_t           info
);
    import bdc_pkg::*;

    localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'(HEIGHT_LIMIT + 2);

    logic [REG_W-1:0] width_reg, width_next;
    logic [REG_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             below_reg, below_next;

    logic [EW_W-1:0]  w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             restart;
    logic [COL_W-1:0] cur_in_col;
    logic [ROW_W-1:0] cur_in_row;
    logic [COL_W-1:0] cur_out_col;
    logic [ROW_W-1:0] cur_out_row;
    logic             cur_below;
    logic [EW_W-1:0]  in_col_inc;
    logic [EW_W-1:0]  out_col_inc;
    logic [ROW_W:0]   out_row_inc;
    logic             emit;
    logic             last;
    logic             in_mark;

    // Effective frame size with out-of-range register values clamped.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = EW_W'(1);
        else if (EW_W'(width_reg) > EW_W'(MAX_WIDTH))
            w_eff = EW_W'(MAX_WIDTH);
        else
            w_eff = EW_W'(width_reg);

        if (height_reg == '0)
            h_eff = ROW_W'(1);
        else if (height_reg > ROW_W'(HEIGHT_LIMIT))
            h_eff = ROW_W'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    // A frame whose output row lies past the height is dropped before this item.
    assign restart     = out_row_reg >= h_eff;
    assign cur_in_col  = restart ? '0 : in_col_reg;
    assign cur_in_row  = restart ? '0 : in_row_reg;
    assign cur_out_col = restart ? '0 : out_col_reg;
    assign cur_out_row = restart ? '0 : out_row_reg;
    assign cur_below   = restart ? 1'b0 : below_reg;

    assign in_col_inc  = EW_W'(cur_in_col) + EW_W'(1);
    assign out_col_inc = EW_W'(cur_out_col) + EW_W'(1);
    assign out_row_inc = {1'b0, cur_out_row} + (ROW_W+1)'(1);

    // Output starts once a full line plus one pixel has gone in.
    assign emit = ((cur_in_row >= ROW_W'(2)) || (cur_in_row == ROW_W'(1) && cur_in_col != '0))
               && (cur_out_row < h_eff);
    assign last = (out_row_inc >= {1'b0, h_eff}) && (out_col_inc >= w_eff);
    assign in_mark = (cur_in_row < h_eff) && is_marked(in_data.pixel_in);

    assign row_addr = cur_in_col;

    // Neighbor qualifiers for the pixel leaving with this item.
    always_comb
    begin
        info.emit       = emit;
        info.last       = last;
        info.out_col    = cur_out_col;
        info.left_ok    = cur_out_col != '0;
        info.right_ok   = out_col_inc < w_eff;
        info.upper_ok   = cur_out_row != '0;
        info.below_ok   = out_row_inc < {1'b0, h_eff};
        info.below_mark = cur_below;
    end

    // Next state of the configuration registers and the scan counters.
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        below_next   = below_reg;

        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
        end

        if (accept)
        begin
            out_col_next = cur_out_col;
            out_row_next = cur_out_row;
            if (emit)
            begin
                if (out_col_inc >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[ROW_W-1:0];
                end
                else
                begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end

            if (emit && last)
            begin
                // Final pixel of the frame: everything starts over.
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                below_next   = 1'b0;
            end
            else
            begin
                below_next  = in_mark;
                in_row_next = cur_in_row;
                if (in_col_inc >= w_eff)
                begin
                    in_col_next = '0;
                    if (cur_in_row < ROW_CAP)
                        in_row_next = cur_in_row + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= REG_W'(600);
            height_reg  <= REG_W'(600);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            below_reg   <= 1'b0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            below_reg   <= below_next;
        end
    end

endmodule

// ===== hw/rtl/bdc_dilate.sv =====
// Dilation stage: upper-mark line store, neighbor evaluation and output register.
// Depends on bdc_pkg; takes the line buffer read data from bdc_row_store.
module bdc_dilate (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  bdc_pkg::scan_info_t       info,
    input  logic [bdc_pkg::PIX_W-1:0] row_rdata,
    output logic                      stage_free,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bdc_pkg::out_item_t        out_data
);
    import bdc_pkg::*;

    logic                 up_mem [MAX_WIDTH];
    logic                 up_rd_reg;
    logic                 fwd_hit_reg;
    logic                 fwd_val_reg;

    logic                 s1_valid_reg, s1_valid_next;
    scan_info_t           s1_info_reg;
    logic [PIX_W-1:0]     center_reg;
    logic                 left_reg;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg;

    logic                 advance;
    logic                 up_wr;
    logic                 c_mark;
    logic                 upper_mark;
    logic                 nb;
    logic [PIX_W-1:0]     result_pix;

    // The held item moves on when it has no result or the output slot is open.
    assign advance    = s1_valid_reg && (!s1_info_reg.emit || !out_valid_reg || out_ready);
    assign stage_free = !s1_valid_reg || advance;
    assign up_wr      = advance && s1_info_reg.emit;

    // Upper-mark store: read for the new item, written back by the departing one.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg   <= up_mem[info.out_col];
            fwd_hit_reg <= up_wr && (s1_info_reg.out_col == info.out_col);
            fwd_val_reg <= c_mark;
        end
        if (up_wr)
            up_mem[s1_info_reg.out_col] <= c_mark;
    end

    // Neighborhood test on the center pixel.
    assign c_mark     = is_marked(center_reg);
    assign upper_mark = fwd_hit_reg ? fwd_val_reg : up_rd_reg;
    assign nb = (s1_info_reg.left_ok  && left_reg)
             || (s1_info_reg.right_ok && is_marked(row_rdata))
             || (s1_info_reg.upper_ok && upper_mark)
             || (s1_info_reg.below_ok && s1_info_reg.below_mark);
    assign result_pix = (!c_mark && nb) ? WHITE_PIXEL : center_reg;

    // Stage and output valid flags.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (up_wr)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the stage and the output slot.
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_info_reg <= info;
        if (advance)
            center_reg <= row_rdata;
        if (up_wr)
        begin
            left_reg                <= c_mark;
            out_data_reg.pixel_out  <= result_pix;
            out_data_reg.frame_last <= s1_info_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A new item never lands on one still held in the stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!s1_valid_reg || advance))
        else $error("bdc_dilate: stage overwritten");

    // A departing item with a result fills the output slot on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        up_wr |=> out_valid_reg)
        else $error("bdc_dilate: result lost");

    // A result only appears after an item left the stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(up_wr))
        else $error("bdc_dilate: result without source item");

    // The output slot is never refilled while its result is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !up_wr)
        else $error("bdc_dilate: waiting result overwritten");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for binary_dilation_cross: streams frames, predicts
// the cross dilation per transaction and compares every result in order.
// Depends on bdc_pkg and the binary_dilation_cross RTL.
`timescale 1ns / 1ps

import bdc_pkg::*;

// Tracks the dilation window from accepted input transactions and checks results.
class dilation_checker;
    int unsigned    width_reg;
    int unsigned    height_reg;
    bit [PIX_W-1:0] row_pixels [MAX_WIDTH];
    bit             above_marks [MAX_WIDTH];
    int unsigned    in_col;
    int unsigned    in_row;
    int unsigned    out_col;
    int unsigned    out_row;
    bit             prev_out_marked;
    bit             prev_in_marked;
    bit [PIX_W-1:0] held_pixel;
    out_item_t      expected_pixels [$];
    int unsigned    error_count;

    function new();
        width_reg   = 600;
        height_reg  = 600;
        held_pixel  = '0;
        error_count = 0;
        restart_scan();
    endfunction

    function void write_register(cfg_reg_t idx, int unsigned value);
        if (idx == REG_FRAME_WIDTH)
            width_reg = value & 11'h7FF;
        else
            height_reg = value & 11'h7FF;
    endfunction

    // Registers out of range are pulled back into [1, top].
    function int unsigned clamp_range(int unsigned v, int unsigned top);
        if (v < 1)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function int unsigned store_col(int unsigned c);
        return (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    endfunction

    function bit blue_full(bit [PIX_W-1:0] p);
        return p[7:0] == MARK_BLUE;
    endfunction

    function void restart_scan();
        in_col          = 0;
        in_row          = 0;
        out_col         = 0;
        out_row         = 0;
        prev_out_marked = 1'b0;
        prev_in_marked  = 1'b0;
    endfunction

    // Advance the window by one accepted transaction; may release one result.
    function void take_pixel(in_item_t item);
        int unsigned    w;
        int unsigned    h;
        int unsigned    ci;
        int unsigned    oc;
        bit [PIX_W-1:0] right_pix;
        bit             in_marked;
        bit             center_marked;
        bit             near_mark;
        bit             last;
        out_item_t      res;
        w = clamp_range(width_reg, MAX_WIDTH);
        h = clamp_range(height_reg, HEIGHT_LIMIT);
        if (out_row >= h)
            restart_scan();
        ci = store_col(in_col);
        // Rows past the frame are flush ticks and never carry a mark.
        in_marked = (in_row < h) && blue_full(item.pixel_in);
        right_pix = row_pixels[ci];
        row_pixels[ci] = item.pixel_in;
        last = 1'b0;
        if ((in_row >= 2 || (in_row == 1 && in_col >= 1)) && out_row < h)
        begin
            oc = store_col(out_col);
            center_marked = blue_full(held_pixel);
            // Neighbors outside the frame count as unmarked.
            near_mark = (out_col >= 1 && prev_out_marked)
                || (out_col + 1 < w && blue_full(right_pix))
                || (out_row >= 1 && above_marks[oc])
                || (out_row + 1 < h && prev_in_marked);
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            res.pixel_out  = (!center_marked && near_mark) ? WHITE_PIXEL : held_pixel;
            res.frame_last = last;
            expected_pixels.push_back(res);
            above_marks[oc] = center_marked;
            prev_out_marked = center_marked;
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
                prev_out_marked = 1'b0;
            end
        end
        held_pixel     = right_pix;
        prev_in_marked = in_marked;
        if (last)
            restart_scan();
        else
        begin
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                if (in_row < HEIGHT_LIMIT + 2)
                    in_row++;
            end
        end
    endfunction

    function void note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("tb: mismatch: %s", msg);
    endfunction

    // Compare one output transaction with the oldest expected pixel.
    function void check_pixel(out_item_t got);
        out_item_t want;
        if (expected_pixels.size() == 0)
        begin
            note_error($sformatf("unexpected result pixel %06h last %0d",
                got.pixel_out, got.frame_last));
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_out !== want.pixel_out || got.frame_last !== want.frame_last)
            note_error($sformatf("expected pixel %06h last %0d, got pixel %06h last %0d",
                want.pixel_out, want.frame_last, got.pixel_out, got.frame_last));
    endfunction
endclass

module tb_top;

    localparam int RANDOM_ITEMS     = 900;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 4000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [REG_W-1:0]     cfg_data  = '0;

    dilation_checker dil_check = new();

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_requests      = 0;
    int unsigned holds_served       = 0;
    int unsigned hold_cycles_left   = 0;
    int unsigned quiet_cycles       = 0;
    int          hold_at            = -1;
    int          pause_at           = -1;

    binary_dilation_cross u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Observe both channels at each edge; results are checked before the new input.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (out_valid && out_ready)
            dil_check.check_pixel(out_data);
        if (in_valid && in_ready)
            dil_check.take_pixel(in_data);
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_cycles_left == 0 && holds_served != hold_requests)
        begin
            holds_served++;
            hold_cycles_left = LONG_HOLD_CYCLES;
        end
        if (hold_cycles_left > 0)
        begin
            hold_cycles_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Ends the run when nothing has moved for too long.
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Offer one input transaction, with random gaps first, and wait for it to be taken.
    task automatic send_pixel(input in_item_t item);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every expected pixel has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (dil_check.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A negative width leaves the width register as it is.
    task automatic write_registers(input int width_val, input int height_val);
        if (width_val >= 0)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_FRAME_WIDTH;
            cfg_data  <= width_val[REG_W-1:0];
            @(posedge clk);
            dil_check.write_register(REG_FRAME_WIDTH, width_val);
        end
        cfg_write <= 1'b1;
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= height_val[REG_W-1:0];
        @(posedge clk);
        dil_check.write_register(REG_FRAME_HEIGHT, height_val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pick_idling(input int unsigned mode);
        case (mode % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
            default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
        endcase
    endtask

    // Random pixel: marked with the given odds, otherwise often just short of a mark.
    function automatic logic [PIX_W-1:0] random_pixel(input int unsigned mark_pct);
        logic [31:0]      raw;
        logic [PIX_W-1:0] p;
        raw = $urandom();
        p   = raw[PIX_W-1:0];
        if ($urandom_range(99) < mark_pct)
            p[7:0] = MARK_BLUE;
        else if ($urandom_range(9) == 0)
            p[7:0] = 8'hFE;
        else if (p[7:0] == MARK_BLUE)
            p[0] = 1'b0;
        return p;
    endfunction

    // One whole frame with random content followed by its flush ticks.
    // The kind bit is mostly right and sometimes wrong, as it must not matter.
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned mark_pct);
        int       i;
        in_item_t item;
        for (i = 0; i < w * h + w + 1; i++)
        begin
            if (i == hold_at)
                hold_requests++;
            if (i == pause_at)
                wait_drained();
            if (i < w * h)
            begin
                item.kind     = ($urandom_range(15) == 0);
                item.pixel_in = random_pixel(mark_pct);
            end
            else
            begin
                item.kind     = ($urandom_range(15) != 0);
                item.pixel_in = random_pixel(50);
            end
            send_pixel(item);
        end
    endtask

    initial
    begin
        logic [PIX_W-1:0] corner_pix [13];
        logic [PIX_W-1:0] tiny_pix [6];
        in_item_t         item;
        int               i;
        int               w_reg;
        int               h_reg;
        int unsigned      w;
        int unsigned      h;
        int unsigned      frame_no;
        int unsigned      random_count;

        // 3x3 frame: marks on corners and edges, near misses, then marked flush ticks.
        corner_pix = '{24'hFF00FF, 24'h000000, 24'h123456,
                       24'h0000FE, 24'hABCDEF, 24'h0000FF,
                       24'hFFFFFF, 24'h7F80FE, 24'h000001,
                       24'h0000FF, 24'h0000FF, 24'hFFFFFF, 24'h0000FF};
        // Two 1x1 frames from zero registers, each with two flush ticks.
        tiny_pix = '{24'hFFFFFF, 24'h0000FF, 24'h0000FF,
                     24'h000000, 24'hFFFFFF, 24'h0000FF};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames.
        write_registers(3, 3);
        for (i = 0; i < 13; i++)
        begin
            item.kind     = i[0];
            item.pixel_in = corner_pix[i];
            send_pixel(item);
        end
        wait_drained();
        write_registers(0, 0);
        for (i = 0; i < 6; i++)
        begin
            item.kind     = ~i[0];
            item.pixel_in = tiny_pix[i];
            send_pixel(item);
        end

        // A sender pause mid-frame, a long output hold-off that fills the block, then zero sizes.
        wait_drained();
        pick_idling(1);
        write_registers(40, 3);
        pause_at = 60;
        run_frame(40, 3, 30);
        pause_at = -1;
        wait_drained();
        pick_idling(0);
        write_registers(64, 2);
        hold_at = 30;
        run_frame(64, 2, 10);
        hold_at = -1;
        wait_drained();
        pick_idling(2);
        write_registers(0, 5);
        run_frame(1, 5, 50);
        wait_drained();
        write_registers(7, 0);
        run_frame(7, 1, 50);

        // Random frames, mostly small, some back to back without a register write.
        random_count = 0;
        frame_no     = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            w_reg = ($urandom_range(19) == 0) ? 0 :
                    ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
            h_reg = ($urandom_range(19) == 0) ? 0 :
                    ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            if (frame_no == 0 || $urandom_range(2) != 0)
            begin
                wait_drained();
                write_registers(w_reg, h_reg);
            end
            pick_idling(frame_no);
            w = dil_check.clamp_range(dil_check.width_reg, MAX_WIDTH);
            h = dil_check.clamp_range(dil_check.height_reg, HEIGHT_LIMIT);
            case ($urandom_range(3))
                0: run_frame(w, h, 5);
                1: run_frame(w, h, 25);
                2: run_frame(w, h, 50);
                default: run_frame(w, h, 90);
            endcase
            random_count += w * h + w + 1;
            frame_no++;
        end

        wait_drained();
        if (dil_check.error_count == 0 && dil_check.expected_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
